// ===== rtl/bqc_pkg.sv =====
package bqc_pkg;

  localparam int DELAY_W   = 32;
  localparam int COEF_W    = 24;
  localparam int GAIN_W    = 16;
  localparam int PROD_W    = DELAY_W + COEF_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int RND_W     = ACC_W - 20;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN = 4'd3;

  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd4096;

  typedef enum logic [1:0] {
    MUL_B0   = 2'd0,
    MUL_A1   = 2'd1,
    MUL_A2   = 2'd2,
    MUL_GAIN = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     ld_y;
    logic     ld_fd;
    logic     ld_sd;
    logic     sec_inc;
    logic     ld_out;
  } dp_cmd_t;

  typedef struct packed {
    logic last_sec;
    logic out_free;
  } dp_stat_t;

  // Q4.20 rounding, half toward +inf
  function automatic logic signed [RND_W-1:0] rnd_coef(input logic signed [ACC_W-1:0] p);
    logic signed [ACC_W-1:0] t;
    t = p + ACC_W'(524288);
    return t[ACC_W-1:20];
  endfunction

  function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [RND_W:0] v);
    logic signed [RND_W:0] hi;
    logic signed [RND_W:0] lo;
    hi = (RND_W+1)'(32'sh7FFFFFFF);
    lo = (RND_W+1)'(32'sh80000000);
    if (v > hi) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      return 32'sh80000000;
    end else begin
      return v[DELAY_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/bqc_ctrl.sv =====
module bqc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  bqc_pkg::dp_stat_t stat,
  output bqc_pkg::dp_cmd_t  cmd
);
  import bqc_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_B0   = 8'b0000_0010,
    ST_Y    = 8'b0000_0100,
    ST_A1   = 8'b0000_1000,
    ST_A2   = 8'b0001_0000,
    ST_SD   = 8'b0010_0000,
    ST_G    = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_B0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_B0;
        end
      end
      ST_B0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_B0;
        state_nxt   = ST_Y;
      end
      ST_Y: begin
        cmd.ld_y  = 1'b1;
        state_nxt = ST_A1;
      end
      ST_A1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_A1;
        state_nxt   = ST_A2;
      end
      ST_A2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_A2;
        cmd.ld_fd   = 1'b1;
        state_nxt   = ST_SD;
      end
      ST_SD: begin
        cmd.ld_sd = 1'b1;
        if (stat.last_sec) begin
          state_nxt = ST_G;
        end else begin
          cmd.sec_inc = 1'b1;
          state_nxt   = ST_B0;
        end
      end
      ST_G: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bqc_dp.sv =====
module bqc_dp #(
  parameter int SECTIONS     = 3,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bqc_pkg::dp_cmd_t                cmd,
  output bqc_pkg::dp_stat_t               stat,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_in,
  output logic signed [SAMPLE_WIDTH-1:0]  sample_out,
  output logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            cfg_valid,
  input  logic [bqc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bqc_pkg::COEF_W-1:0]      cfg_data
);
  import bqc_pkg::*;

  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int OUT_W = PROD_W - 12;
  localparam logic signed [OUT_W-1:0] OUT_MAX = (OUT_W'(1) <<< (SAMPLE_WIDTH - 1)) - OUT_W'(1);
  localparam logic signed [OUT_W-1:0] OUT_MIN = -OUT_MAX - OUT_W'(1);

  logic signed [COEF_W-1:0]  b0_r, a1_r, a2_r;
  logic signed [GAIN_W-1:0]  gain_r;
  logic signed [DELAY_W-1:0] fd_r [SECTIONS];
  logic signed [DELAY_W-1:0] sd_r [SECTIONS];
  logic signed [DELAY_W-1:0] v_r, y_r;
  logic signed [PROD_W-1:0]  prod_r, bv_r;
  logic [SEC_W-1:0]          sec_r;
  logic signed [SAMPLE_WIDTH-1:0] out_r;
  logic                      out_valid_r;

  logic signed [DELAY_W-1:0] mul_a;
  logic signed [COEF_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [DELAY_W-1:0] y_nxt, fd_nxt, sd_nxt;
  logic signed [PROD_W-1:0]  og_sum;
  logic signed [OUT_W-1:0]   og;
  logic signed [SAMPLE_WIDTH-1:0] out_nxt;

  always_comb begin
    case (cmd.mul_sel)
      MUL_B0:   mul_b = b0_r;
      MUL_A1:   mul_b = a1_r;
      MUL_A2:   mul_b = a2_r;
      MUL_GAIN: mul_b = COEF_W'(gain_r);
      default:  mul_b = b0_r;
    endcase
    mul_a    = (cmd.mul_sel inside {MUL_A1, MUL_A2}) ? y_r : v_r;
    prod_nxt = mul_a * mul_b;

    y_nxt  = sat_delay((RND_W+1)'(rnd_coef(ACC_W'(prod_r))) + (RND_W+1)'(fd_r[sec_r]));
    fd_nxt = sat_delay((RND_W+1)'(rnd_coef(-ACC_W'(prod_r))) + (RND_W+1)'(sd_r[sec_r]));
    sd_nxt = sat_delay((RND_W+1)'(rnd_coef(-ACC_W'(bv_r) - ACC_W'(prod_r))));

    og_sum = prod_r + PROD_W'(2048);
    og     = og_sum[PROD_W-1:12];
    if (og > OUT_MAX) begin
      out_nxt = OUT_MAX[SAMPLE_WIDTH-1:0];
    end else if (og < OUT_MIN) begin
      out_nxt = OUT_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      out_nxt = og[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r   <= '0;
      a1_r   <= '0;
      a2_r   <= '0;
      gain_r <= GAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COEF_B0:  b0_r   <= cfg_data;
        REG_COEF_A1:  a1_r   <= cfg_data;
        REG_COEF_A2:  a2_r   <= cfg_data;
        REG_OUT_GAIN: gain_r <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SECTIONS; i++) begin
        fd_r[i] <= '0;
        sd_r[i] <= '0;
      end
    end else begin
      if (cmd.ld_fd) begin
        fd_r[sec_r] <= fd_nxt;
      end
      if (cmd.ld_sd) begin
        sd_r[sec_r] <= sd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        sec_r <= '0;
      end else if (cmd.sec_inc) begin
        sec_r <= sec_r + SEC_W'(1);
      end
      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      v_r <= DELAY_W'(sample_in);
    end else if (cmd.ld_sd) begin
      v_r <= y_r;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.ld_y) begin
      y_r  <= y_nxt;
      bv_r <= prod_r;
    end
    if (cmd.ld_out) begin
      out_r <= out_nxt;
    end
  end

  assign stat.last_sec = (sec_r == SEC_W'(SECTIONS - 1));
  assign stat.out_free = !out_valid_r || out_ready;
  assign sample_out    = out_r;
  assign out_valid     = out_valid_r;

endmodule

// ===== rtl/biquad_bandpass_cascade_top.sv =====
// One sample is processed at a time: in_tready is high only while idle, so the
// next sample is taken in after the last one is loaded into the output register.
// The single shared 32x24 multiplier does three products per section plus the gain.
// A finished sample waits in the output register while the next one is taken in.
// Reset (rst_n low, synchronous) clears delay words, control and loads coefficient
// defaults: b0 = a1 = a2 = 0, gain = 1.0.
module biquad_bandpass_cascade_top #(
  parameter int SECTIONS     = 3,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    in_tdata,   // sample_in
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    out_tdata,  // sample_out
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bqc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bqc_pkg::COEF_W-1:0]           cfg_data
);
  import bqc_pkg::*;

  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic [SAMPLE_WIDTH-1:0]        sample_out_u;

  bqc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bqc_dp #(
    .SECTIONS     (SECTIONS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .sample_in  (in_tdata[SAMPLE_WIDTH-1:0]),
    .sample_out (sample_out),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  assign cfg_ready    = 1'b1;
  assign sample_out_u = sample_out;
  assign out_tdata    = TDATA_W'(sample_out_u);

endmodule

// ===== tb/biquad_bandpass_cascade_top_tb.sv =====
`timescale 1ns / 100ps

module biquad_bandpass_cascade_top_tb;
  import bqc_pkg::*;

  localparam int SECTIONS      = 3;
  localparam int SAMPLE_W      = 24;
  localparam int DATA_W        = ((SAMPLE_W + 7) / 8) * 8;
  localparam int LATENCY       = 5 * SECTIONS + 2;
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_AFTER    = 250;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 100;

  localparam logic [COEF_W-1:0]   SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [COEF_W-1:0]   SAMPLE_MIN = 24'h800000;
  localparam logic [COEF_W-1:0]   COEF_MAX   = 24'h7FFFFF;
  localparam logic [COEF_W-1:0]   COEF_MIN   = 24'h800000;
  localparam logic [COEF_W-1:0]   Q20_ONE    = 24'h100000;
  localparam logic [GAIN_W-1:0]   GAIN_MAX   = 16'h7FFF;
  localparam logic [GAIN_W-1:0]   GAIN_MIN   = 16'h8000;

  class biquad_scoreboard;
    logic signed [COEF_W-1:0] coef_b0;
    logic signed [COEF_W-1:0] coef_a1;
    logic signed [COEF_W-1:0] coef_a2;
    logic signed [GAIN_W-1:0] gain;
    longint                   first_dly[SECTIONS];
    longint                   second_dly[SECTIONS];
    logic [SAMPLE_W-1:0]      expected_samples[$];
    int                       errors;

    function new();
      coef_b0 = '0;
      coef_a1 = '0;
      coef_a2 = '0;
      gain    = GAIN_RESET;
      errors  = 0;
      foreach (first_dly[i]) begin
        first_dly[i]  = 0;
        second_dly[i] = 0;
      end
    endfunction

    function longint round_half_up(longint p, int n);
      return (p + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function longint saturate(longint v, int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      case (idx)
        REG_COEF_B0:  coef_b0 = data;
        REG_COEF_A1:  coef_a1 = data;
        REG_COEF_A2:  coef_a2 = data;
        REG_OUT_GAIN: gain    = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [SAMPLE_W-1:0] raw);
      longint v;
      longint y;
      longint r;
      v = longint'($signed(raw));
      for (int s = 0; s < SECTIONS; s++) begin
        y = saturate(round_half_up(longint'(coef_b0) * v, 20) + first_dly[s], DELAY_W);
        first_dly[s] = saturate(round_half_up(-longint'(coef_a1) * y, 20) + second_dly[s],
                                DELAY_W);
        second_dly[s] = saturate(round_half_up(-longint'(coef_b0) * v
                                               - longint'(coef_a2) * y, 20), DELAY_W);
        v = y;
      end
      r = saturate(round_half_up(v * longint'(gain), 12), SAMPLE_W);
      expected_samples.push_back(r[SAMPLE_W-1:0]);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [SAMPLE_W-1:0] got);
      logic [SAMPLE_W-1:0] want;
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("sample_out %06h with no sample pending", got));
      end else begin
        want = expected_samples.pop_front();
        if (got !== want)
          report_mismatch($sformatf("sample_out got %06h expected %06h", got, want));
      end
    endtask

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_W-1:0]     out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_COEF_B0;
  logic [COEF_W-1:0]     cfg_data   = '0;

  biquad_scoreboard sb;
  int results_seen = 0;
  int idle_cycles  = 0;
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  bit holding      = 1'b0;
  bit hold_done    = 1'b0;

  biquad_bandpass_cascade_top #(
    .SECTIONS    (SECTIONS),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_input(in_tdata[SAMPLE_W-1:0]);
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata[SAMPLE_W-1:0]);
        results_seen++;
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("biquad_bandpass_cascade_top_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(99) < 85) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // receiver: random stalls plus one long hold-off to back up the cascade
  initial begin
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        holding = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_tready <= 1'b1;
        holding   = 1'b0;
        hold_done = 1'b1;
      end else if (rst_n && $urandom_range(99) < rx_stall_pct) begin
        out_tready <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] a1,
                            input logic [COEF_W-1:0] a2, input logic [COEF_W-1:0] gain_word);
    wait_drained();
    // out-of-range index must be ignored
    write_cfg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_OUT_GAIN + 1)),
              COEF_W'($urandom));
    write_cfg(REG_COEF_B0, b0);
    write_cfg(REG_COEF_A1, a1);
    write_cfg(REG_COEF_A2, a2);
    write_cfg(REG_OUT_GAIN, gain_word);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_W'(s);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = (!holding && $urandom_range(99) < tx_gap_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 45) return SAMPLE_W'($urandom);
    if (r < 75) return SAMPLE_W'(int'($urandom_range(8191)) - 4096);
    if (r < 85) begin
      case ($urandom_range(3))
        0: return SAMPLE_MAX;
        1: return SAMPLE_MIN;
        2: return '0;
        default: return '1;
      endcase
    end
    r = $urandom_range(SAMPLE_W - 1);
    return $urandom_range(1) ? ~(SAMPLE_W'(1) << r) : (SAMPLE_W'(1) << r);
  endfunction

  function automatic logic [COEF_W-1:0] pick_extreme();
    return $urandom_range(1) ? COEF_MAX : COEF_MIN;
  endfunction

  initial begin
    logic [COEF_W-1:0] b0;
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
    logic [COEF_W-1:0] gw;

    sb = new();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset coefficients: b0 = 0 gives silence
    tx_gap_pct   = 30;
    rx_stall_pct = 30;
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    stop_input();

    // large, unstable coefficients: internal and output saturation, gain high bits junk
    load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, {8'hA5, GAIN_MAX});
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_W'(1));
    send_sample('1);
    send_sample('0);
    send_sample(SAMPLE_MAX);
    stop_input();

    load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, {8'h5A, GAIN_MIN});
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(SAMPLE_W'(1));
    send_sample('1);
    stop_input();

    // unit b0, no feedback: y = x - x[n-2] per section
    load_coefs(Q20_ONE, '0, '0, {8'hFF, GAIN_RESET});
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_W'(12345));
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_W'(-777));
    send_sample('0);
    send_sample('0);
    stop_input();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: begin
          b0 = COEF_W'($urandom_range(300000));
          a1 = COEF_W'(int'($urandom_range(1 << 22)) - (1 << 21));
          a2 = COEF_W'($urandom_range(1 << 20));
          gw = {COEF_W'($urandom)} & {8'hFF, 16'h0} | COEF_W'($urandom_range(8192, 1024));
        end
        1: begin
          b0 = COEF_W'($urandom);
          a1 = COEF_W'($urandom);
          a2 = COEF_W'($urandom);
          gw = COEF_W'($urandom);
        end
        2: begin
          b0 = pick_extreme();
          a1 = pick_extreme();
          a2 = pick_extreme();
          gw = {8'h00, $urandom_range(1) ? GAIN_MAX : GAIN_MIN};
        end
        default: begin
          b0 = Q20_ONE;
          a1 = '0;
          a2 = '0;
          gw = COEF_W'($urandom);
        end
      endcase
      load_coefs(b0, a1, a2, gw);
      tx_gap_pct   = (ph % 4 == 0) ? 0 : $urandom_range(60, 5);
      rx_stall_pct = (ph % 4 == 0) ? 0 : $urandom_range(60, 5);
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(pick_sample());
      stop_input();
    end

    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.errors == 0) begin
      $display("biquad_bandpass_cascade_top_tb: done, clean");
    end else begin
      $display("biquad_bandpass_cascade_top_tb: done, errors");
    end
    $finish;
  end

endmodule
